// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the rtl.
// ----------------------------------------------------------------------------
// every check runs on the rising edge of clk and is off while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge
`define BRES_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression must never be true at a clock edge
`define BRES_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== hw/rtl/bres_pkg.sv =====
// ----------------------------------------------------------------------------
// bres_pkg
// Shared types and constants of the line rasterizer: coordinate and error
// widths, the command passed from front to back, pixel and status records.
// ----------------------------------------------------------------------------
`default_nettype none

package bres_pkg;

    localparam int COORD_BITS   = 9;
    localparam int COLOR_BITS   = 16;
    // error stays within [-major_delta, major_delta], two extra bits cover it
    localparam int ERR_BITS     = COORD_BITS + 2;

    localparam int CMD_DEPTH    = 4;
    localparam int CMD_PTR_BITS = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_BITS = CMD_PTR_BITS + 1;

    localparam int OUT_DEPTH    = 2;
    localparam int OUT_PTR_BITS = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_BITS = OUT_PTR_BITS + 1;

    typedef logic [COORD_BITS-1:0]      coord_t;
    typedef logic [COLOR_BITS-1:0]      color_t;
    typedef logic signed [ERR_BITS-1:0] err_t;

    typedef enum logic {
        FUNC_START   = 1'b0,
        FUNC_ADVANCE = 1'b1
    } func_t;

    // classified request, line already ordered along the major axis
    typedef struct packed {
        func_t  func;
        logic   steep;
        coord_t major_start;
        coord_t major_end;
        coord_t minor_start;
        logic   minor_step_down;
        coord_t major_delta;
        coord_t minor_delta;
        color_t color;
    } cmd_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        color_t color;
        logic   last;
    } pixel_t;

    typedef struct packed {
        logic                    full;
        logic                    valid;
        logic [CMD_CNT_BITS-1:0] count;
    } queue_status_t;

    typedef struct packed {
        logic                    active;
        logic                    cmd_pop;
        logic [OUT_CNT_BITS-1:0] out_count;
    } back_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bresenham_line_rasterizer.sv =====
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer
// Integer Bresenham line generator with queue-style request and result ports.
// ----------------------------------------------------------------------------
// A start request (func 0) loads two endpoints and a colour and gives no
// pixel; each advance request (func 1) gives the next pixel of the line, with
// last set on the final one, and the end pixel itself is not drawn. Advance
// requests while no line is active are consumed silently. Requests are taken
// at one per clock while the command queue is not full: the front classifies
// a request in the cycle it is pushed and writes it into a four-entry command
// queue; the stepper retires one queued request per clock, stalling only on
// an advance of an active line while the result queue is full, with a single
// add, compare and subtract on the error term; pixels wait in a two-entry
// result queue. A pixel reaches the ports through the command queue and the
// result queue registers, at one pixel per clock sustained while pop keeps up.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bresenham_line_rasterizer (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            push,
    output logic                                 full,
    input  wire logic                            func,
    input  wire logic [bres_pkg::COORD_BITS-1:0] x_start,
    input  wire logic [bres_pkg::COORD_BITS-1:0] y_start,
    input  wire logic [bres_pkg::COORD_BITS-1:0] x_end,
    input  wire logic [bres_pkg::COORD_BITS-1:0] y_end,
    input  wire logic [bres_pkg::COLOR_BITS-1:0] color,
    output logic                                 empty,
    input  wire logic                            pop,
    output logic [bres_pkg::COORD_BITS-1:0]      pixel_x,
    output logic [bres_pkg::COORD_BITS-1:0]      pixel_y,
    output logic [bres_pkg::COLOR_BITS-1:0]      pixel_color,
    output logic                                 last
);
    import bres_pkg::*;

    cmd_t          front_cmd;
    cmd_t          head_cmd;
    queue_status_t cmd_status;
    back_status_t  back_status;
    logic          cmd_pop;

    // request classification
    bres_front u_front (
        .func    (func),
        .x_start (x_start),
        .y_start (y_start),
        .x_end   (x_end),
        .y_end   (y_end),
        .color   (color),
        .cmd     (front_cmd)
    );

    // command queue between front and stepper
    bres_cmd_queue u_cmd_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_cmd (front_cmd),
        .pop    (cmd_pop),
        .rd_cmd (head_cmd),
        .status (cmd_status)
    );

    // stepper and result queue
    bres_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (head_cmd),
        .cmd_valid   (cmd_status.valid),
        .cmd_pop     (cmd_pop),
        .empty       (empty),
        .pop         (pop),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_color (pixel_color),
        .last        (last),
        .status      (back_status)
    );

    assign full = cmd_status.full;

    // checks
    `BRES_ASSERT_NEVER(a_cmd_count_bound, cmd_status.count > CMD_CNT_BITS'(CMD_DEPTH), "command queue overfilled")
    `BRES_ASSERT_NEVER(a_out_count_bound, back_status.out_count > OUT_CNT_BITS'(OUT_DEPTH), "result queue overfilled")
    `BRES_ASSERT(a_no_pixel_drop, (back_status.cmd_pop && head_cmd.func == FUNC_ADVANCE && back_status.active) |-> (back_status.out_count != OUT_CNT_BITS'(OUT_DEPTH)), "pixel emitted into a full result queue")
    `BRES_ASSERT(a_stepper_progress, (cmd_status.valid && back_status.out_count == '0) |-> back_status.cmd_pop, "stepper stalled with room for a result")

endmodule

`default_nettype wire

// ===== hw/rtl/bres_front.sv =====
// ----------------------------------------------------------------------------
// bres_front
// Classifies an incoming request: for a line start it finds the major axis,
// orders the endpoints so the major coordinate rises and works out deltas.
// ----------------------------------------------------------------------------
`default_nettype none

module bres_front (
    input  wire logic                        func,
    input  wire logic [bres_pkg::COORD_BITS-1:0] x_start,
    input  wire logic [bres_pkg::COORD_BITS-1:0] y_start,
    input  wire logic [bres_pkg::COORD_BITS-1:0] x_end,
    input  wire logic [bres_pkg::COORD_BITS-1:0] y_end,
    input  wire logic [bres_pkg::COLOR_BITS-1:0] color,
    output bres_pkg::cmd_t                   cmd
);
    import bres_pkg::*;

    coord_t dx;
    coord_t dy;
    logic   steep;
    coord_t ma;
    coord_t mb;
    coord_t na;
    coord_t nb;
    logic   swap;
    coord_t major_lo;
    coord_t major_hi;
    coord_t minor_a;
    coord_t minor_b;

    // absolute deltas and steepness
    always_comb
    begin
        dx    = (x_start > x_end) ? (x_start - x_end) : (x_end - x_start);
        dy    = (y_start > y_end) ? (y_start - y_end) : (y_end - y_start);
        steep = dy > dx;
    end

    // map to major/minor axes and order along the major axis
    always_comb
    begin
        ma       = steep ? y_start : x_start;
        na       = steep ? x_start : y_start;
        mb       = steep ? y_end   : x_end;
        nb       = steep ? x_end   : y_end;
        swap     = ma > mb;
        major_lo = swap ? mb : ma;
        major_hi = swap ? ma : mb;
        minor_a  = swap ? nb : na;
        minor_b  = swap ? na : nb;
    end

    // build the command record
    always_comb
    begin
        cmd.func            = func_t'(func);
        cmd.steep           = steep;
        cmd.major_start     = major_lo;
        cmd.major_end       = major_hi;
        cmd.minor_start     = minor_a;
        cmd.minor_step_down = !(minor_a < minor_b);
        cmd.major_delta     = major_hi - major_lo;
        cmd.minor_delta     = (minor_a > minor_b) ? (minor_a - minor_b)
                                                  : (minor_b - minor_a);
        cmd.color           = color;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bres_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// bres_cmd_queue
// Short first-in first-out queue of classified requests between the front
// and the stepper, so either side can stall without holding up the other.
// ----------------------------------------------------------------------------
`default_nettype none

module bres_cmd_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire bres_pkg::cmd_t    wr_cmd,
    input  wire logic              pop,
    output bres_pkg::cmd_t         rd_cmd,
    output bres_pkg::queue_status_t status
);
    import bres_pkg::*;

    cmd_t                    entry_reg [CMD_DEPTH];
    logic [CMD_PTR_BITS-1:0] wr_ptr_reg;
    logic [CMD_PTR_BITS-1:0] wr_ptr_next;
    logic [CMD_PTR_BITS-1:0] rd_ptr_reg;
    logic [CMD_PTR_BITS-1:0] rd_ptr_next;
    logic [CMD_CNT_BITS-1:0] count_reg;
    logic [CMD_CNT_BITS-1:0] count_next;
    logic                    do_push;
    logic                    do_pop;

    // handshake qualification
    always_comb
    begin
        do_push = push && !status.full;
        do_pop  = pop && status.valid;
    end

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_push ? (wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? (rd_ptr_reg + 1'b1) : rd_ptr_reg;
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    // head of queue and status
    always_comb
    begin
        rd_cmd       = entry_reg[rd_ptr_reg];
        status.full  = count_reg == CMD_CNT_BITS'(CMD_DEPTH);
        status.valid = count_reg != '0;
        status.count = count_reg;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bres_back.sv =====
// ----------------------------------------------------------------------------
// bres_back
// Bresenham stepper: loads a line on a start request and, while it is active,
// emits one pixel per advance request into a small result queue at the outputs.
// ----------------------------------------------------------------------------
`default_nettype none

module bres_back (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire bres_pkg::cmd_t                  cmd,
    input  wire logic                            cmd_valid,
    output logic                                 cmd_pop,
    output logic                                 empty,
    input  wire logic                            pop,
    output logic [bres_pkg::COORD_BITS-1:0]      pixel_x,
    output logic [bres_pkg::COORD_BITS-1:0]      pixel_y,
    output logic [bres_pkg::COLOR_BITS-1:0]      pixel_color,
    output logic                                 last,
    output bres_pkg::back_status_t               status
);
    import bres_pkg::*;

    // line state
    logic   active_reg;
    logic   active_next;
    logic   steep_reg;
    coord_t major_pos_reg;
    coord_t major_pos_next;
    coord_t major_end_reg;
    coord_t minor_pos_reg;
    coord_t minor_pos_next;
    logic   step_down_reg;
    coord_t major_delta_reg;
    coord_t minor_delta_reg;
    err_t   err_reg;
    err_t   err_next;
    color_t color_reg;

    // result queue
    pixel_t                  out_q_reg [OUT_DEPTH];
    logic [OUT_PTR_BITS-1:0] out_wr_ptr_reg;
    logic [OUT_PTR_BITS-1:0] out_wr_ptr_next;
    logic [OUT_PTR_BITS-1:0] out_rd_ptr_reg;
    logic [OUT_PTR_BITS-1:0] out_rd_ptr_next;
    logic [OUT_CNT_BITS-1:0] out_count_reg;
    logic [OUT_CNT_BITS-1:0] out_count_next;

    logic                  out_full;
    logic                  out_pop;
    logic                  is_start;
    logic                  load;
    logic                  emit;
    logic [COORD_BITS:0]   major_inc;
    logic                  fin;
    err_t                  err_sum;
    err_t                  err_adj;
    logic                  minor_step;
    err_t                  err_init;
    pixel_t                pix;

    // request scheduling: start and idle advances never need result space
    always_comb
    begin
        out_full = out_count_reg == OUT_CNT_BITS'(OUT_DEPTH);
        empty    = out_count_reg == '0;
        out_pop  = pop && !empty;
        is_start = cmd.func == FUNC_START;
        cmd_pop  = cmd_valid && (is_start || !active_reg || !out_full);
        load     = cmd_pop && is_start;
        emit     = cmd_pop && !is_start && active_reg;
    end

    // one bresenham step
    always_comb
    begin
        major_inc  = {1'b0, major_pos_reg} + 1'b1;
        fin        = major_inc >= {1'b0, major_end_reg};
        err_sum    = err_reg + $signed({2'b00, minor_delta_reg});
        err_adj    = err_sum - $signed({2'b00, major_delta_reg});
        minor_step = !err_sum[ERR_BITS-1] && (err_sum != '0);
        err_init   = '0 - $signed({2'b00, (cmd.major_delta >> 1)});
        pix.x      = steep_reg ? minor_pos_reg : major_pos_reg;
        pix.y      = steep_reg ? major_pos_reg : minor_pos_reg;
        pix.color  = color_reg;
        pix.last   = fin;
    end

    // next line state
    always_comb
    begin
        active_next    = active_reg;
        major_pos_next = major_pos_reg;
        minor_pos_next = minor_pos_reg;
        err_next       = err_reg;
        if (load)
        begin
            active_next    = cmd.major_start < cmd.major_end;
            major_pos_next = cmd.major_start;
            minor_pos_next = cmd.minor_start;
            err_next       = err_init;
        end
        else if (emit)
        begin
            major_pos_next = major_inc[COORD_BITS-1:0];
            if (fin)
            begin
                active_next = 1'b0;
            end
            if (minor_step)
            begin
                minor_pos_next = step_down_reg ? (minor_pos_reg - 1'b1)
                                               : (minor_pos_reg + 1'b1);
                err_next       = err_adj;
            end
            else
            begin
                err_next = err_sum;
            end
        end
    end

    // result queue pointers and count
    always_comb
    begin
        out_wr_ptr_next = emit    ? (out_wr_ptr_reg + 1'b1) : out_wr_ptr_reg;
        out_rd_ptr_next = out_pop ? (out_rd_ptr_reg + 1'b1) : out_rd_ptr_reg;
        unique case ({emit, out_pop})
            2'b10:   out_count_next = out_count_reg + 1'b1;
            2'b01:   out_count_next = out_count_reg - 1'b1;
            default: out_count_next = out_count_reg;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= 1'b0;
            out_wr_ptr_reg <= '0;
            out_rd_ptr_reg <= '0;
            out_count_reg  <= '0;
        end
        else
        begin
            active_reg     <= active_next;
            out_wr_ptr_reg <= out_wr_ptr_next;
            out_rd_ptr_reg <= out_rd_ptr_next;
            out_count_reg  <= out_count_next;
        end
    end

    // line payload registers
    always_ff @(posedge clk)
    begin
        major_pos_reg <= major_pos_next;
        minor_pos_reg <= minor_pos_next;
        err_reg       <= err_next;
        if (load)
        begin
            steep_reg       <= cmd.steep;
            major_end_reg   <= cmd.major_end;
            step_down_reg   <= cmd.minor_step_down;
            major_delta_reg <= cmd.major_delta;
            minor_delta_reg <= cmd.minor_delta;
            color_reg       <= cmd.color;
        end
    end

    // result storage
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_q_reg[out_wr_ptr_reg] <= pix;
        end
    end

    // oldest result and status
    always_comb
    begin
        pixel_x          = out_q_reg[out_rd_ptr_reg].x;
        pixel_y          = out_q_reg[out_rd_ptr_reg].y;
        pixel_color      = out_q_reg[out_rd_ptr_reg].color;
        last             = out_q_reg[out_rd_ptr_reg].last;
        status.active    = active_reg;
        status.cmd_pop   = cmd_pop;
        status.out_count = out_count_reg;
    end

endmodule

`default_nettype wire
